FILE: hdl/hall_angle_decoder_with_direction_macros.svh
// ----------------------------------------------------------------------------
// Hall angle decoder assertion macros
// Clocked assertion helpers for the Hall angle decoder. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HALL_ANGLE_DECODER_WITH_DIRECTION_MACROS_SVH
`define HALL_ANGLE_DECODER_WITH_DIRECTION_MACROS_SVH

`ifndef SYNTHESIS
// Assert a property on every rising edge outside reset
`define HADD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition never holds on a rising edge outside reset
`define HADD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HADD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HADD_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: hdl/hadd_pkg.sv
// ----------------------------------------------------------------------------
// Hall angle decoder package
// Payload and configuration types, codes and the sector angle table.
// ----------------------------------------------------------------------------
package hadd_pkg;

    localparam int ANGLE_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic hall_u;
        logic hall_v;
        logic hall_w;
        logic run_active;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] elec_angle;
        logic [ANGLE_W-1:0] abs_position;
        logic [1:0]         direction;
        logic [1:0]         fault;
    } t_out;

    typedef struct packed {
        logic               decode_enable;
        logic               angle_mirror;
        logic               fault_enable;
        logic [ANGLE_W-1:0] rotor_zero;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [1:0]         fault;
    } t_sec;

    typedef struct packed {
        logic [1:0]                direction;
        logic signed [ANGLE_W-1:0] count;
    } t_dir;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIRROR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_ENABLE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_ZERO    = 8'd3;

    // Direction and fault codes
    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_FWD    = 2'd1;
    localparam logic [1:0] DIR_BWD    = 2'd2;
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_HIGH = 2'd1;
    localparam logic [1:0] FAULT_LOW  = 2'd2;

    // Hall codes with no sector
    localparam logic [2:0] CODE_ALL_LOW  = 3'd0;
    localparam logic [2:0] CODE_ALL_HIGH = 3'd7;

    localparam logic signed [ANGLE_W-1:0] STEP_THRESHOLD = 16'sd1820;
    localparam logic signed [ANGLE_W-1:0] COUNT_MAX      = 16'sd32767;
    localparam logic signed [ANGLE_W-1:0] COUNT_MIN      = -16'sd32767;
    localparam logic signed [ANGLE_W-1:0] DIR_DECIDE     = 16'sd2;

    // Electrical angle per Hall sector, full turn is 65536
    function automatic logic [ANGLE_W-1:0] sector_angle(input logic [2:0] code);
        logic [ANGLE_W-1:0] a;
        unique case (code)
            3'd1:    a = 16'd60074;
            3'd2:    a = 16'd38229;
            3'd3:    a = 16'd49152;
            3'd4:    a = 16'd16384;
            3'd5:    a = 16'd5461;
            3'd6:    a = 16'd27306;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/hadd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Hall angle decoder configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hadd_cfg_regs import hadd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DECODE_ENABLE: r_cfg.decode_enable <= i_cfg_data[0];
                REG_ANGLE_MIRROR:  r_cfg.angle_mirror  <= i_cfg_data[0];
                REG_FAULT_ENABLE:  r_cfg.fault_enable  <= i_cfg_data[0];
                REG_ROTOR_ZERO:    r_cfg.rotor_zero    <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/hadd_sector_decode.sv
// ----------------------------------------------------------------------------
// Hall sector decoder
// Maps the Hall code to an electrical angle, holds the last valid angle and
// flags invalid codes while the rotor runs and faults are enabled.
// ----------------------------------------------------------------------------
module hadd_sector_decode import hadd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    input  t_in  i_hall,
    input  t_cfg i_cfg,
    output t_sec o_sec
);

    logic [ANGLE_W-1:0] r_held;
    logic [ANGLE_W-1:0] n_held;
    logic [ANGLE_W-1:0] w_table;
    logic [2:0]         w_code;
    logic               w_code_ok;
    logic [1:0]         w_fault;

    assign w_code    = {i_hall.hall_u, i_hall.hall_v, i_hall.hall_w};
    assign w_code_ok = (w_code != CODE_ALL_LOW) && (w_code != CODE_ALL_HIGH);
    assign w_table   = sector_angle(w_code);

    always_comb begin
        n_held  = r_held;
        w_fault = FAULT_NONE;
        if (i_cfg.decode_enable) begin
            if (w_code_ok) begin
                // mirror as 65536 - angle; the table holds no zero entry
                n_held = i_cfg.angle_mirror ? (~w_table + 16'd1) : w_table;
            end else if (i_hall.run_active && i_cfg.fault_enable) begin
                w_fault = (w_code == CODE_ALL_HIGH) ? FAULT_HIGH : FAULT_LOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_advance) begin
            r_held <= n_held;
        end
    end

    assign o_sec.angle = n_held;
    assign o_sec.fault = w_fault;

endmodule

FILE: hdl/hadd_dir_track.sv
// ----------------------------------------------------------------------------
// Hall direction tracker
// Steps a saturating counter on large wrapped angle changes and judges the
// direction of rotation from it.
// ----------------------------------------------------------------------------
module hadd_dir_track import hadd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [ANGLE_W-1:0] i_angle,
    output t_dir               o_dir
);

    logic [ANGLE_W-1:0]        r_ref;
    logic [ANGLE_W-1:0]        n_ref;
    logic signed [ANGLE_W-1:0] r_count;
    logic signed [ANGLE_W-1:0] n_count;
    logic signed [ANGLE_W-1:0] w_delta;
    logic [1:0]                w_dir;

    // 16-bit wrap gives the signed change directly
    assign w_delta = $signed(i_angle - r_ref);

    always_comb begin
        n_ref   = r_ref;
        n_count = r_count;
        if (w_delta > STEP_THRESHOLD) begin
            n_ref = i_angle;
            if (r_count < COUNT_MAX) begin
                n_count = r_count + 16'sd1;
            end
        end else if (w_delta < -STEP_THRESHOLD) begin
            n_ref = i_angle;
            if (r_count > COUNT_MIN) begin
                n_count = r_count - 16'sd1;
            end
        end
    end

    always_comb begin
        if (n_count > DIR_DECIDE) begin
            w_dir = DIR_FWD;
        end else if (n_count < -DIR_DECIDE) begin
            w_dir = DIR_BWD;
        end else begin
            w_dir = DIR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= '0;
            r_count <= '0;
        end else if (i_advance) begin
            r_ref   <= n_ref;
            r_count <= n_count;
        end
    end

    assign o_dir.direction = w_dir;
    assign o_dir.count     = r_count;

endmodule

FILE: hdl/hall_angle_decoder_with_direction.sv
// Flow: an accepted item waits in the input register, then moves into the result
// register (o_out_valid) once that is free or draining. Throughput: one item per
// cycle unless i_out_ready stalls the output; input register, decode logic and
// result register run back to back, state update sits between the two registers.
// Reset (synchronous, active low) clears the configuration, held and
// reference angles, the direction counter and both valid flags.
// ----------------------------------------------------------------------------
// Hall angle decoder with direction
// Decodes UVW Hall samples to electrical angle, absolute position, rotation
// direction and sensor fault.
// ----------------------------------------------------------------------------
`include "hall_angle_decoder_with_direction_macros.svh"

module hall_angle_decoder_with_direction import hadd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    t_out n_out;
    logic w_advance;
    t_cfg w_cfg;
    t_sec w_sec;
    t_dir w_dir;

    // move the held item on when the result register is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    hadd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    hadd_sector_decode u_sector (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_hall    (r_in),
        .i_cfg     (w_cfg),
        .o_sec     (w_sec)
    );

    hadd_dir_track u_dir (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_angle   (w_sec.angle),
        .o_dir     (w_dir)
    );

    always_comb begin
        n_out.elec_angle   = w_sec.angle;
        n_out.abs_position = w_sec.angle + w_cfg.rotor_zero;
        n_out.direction    = w_dir.direction;
        n_out.fault        = w_sec.fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `HADD_NEVER(a_in_no_overrun, i_clk, i_rst_n, i_in_valid && o_in_ready && r_in_valid && !w_advance, "input register overwritten before it moved on")
    `HADD_NEVER(a_count_in_range, i_clk, i_rst_n, $signed(w_dir.count) < COUNT_MIN, "direction counter below its limit")
    `HADD_NEVER(a_fault_gated, i_clk, i_rst_n, w_advance && !w_cfg.fault_enable && w_sec.fault != FAULT_NONE, "fault raised with faults disabled")
    `HADD_ASSERT(a_result_loaded, i_clk, i_rst_n, w_advance |=> o_out_valid, "result register not loaded after advance")

endmodule

FILE: tb/sv/tb_hall_angle_decoder_with_direction.sv
// ----------------------------------------------------------------------------
// Hall angle decoder with direction: self-checking testbench
// Sends Hall samples over the input channel and writes registers between
// phases. A predictor tracks the held angle, the reference angle and the
// direction counter, and every result is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_hall_angle_decoder_with_direction;
    import hadd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 235;
    localparam int SWEEP_UP = 24;
    localparam int SWEEP_DOWN = 48;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_ROTOR_ZERO + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
    // Hall codes in order of rising electrical angle
    localparam logic [2:0] FWD_CODES [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_in  hall_samples_q[$];
    t_out expected_results_q[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    // Predictor state
    t_cfg        cfg_shadow;
    logic [15:0] predicted_angle;
    logic [15:0] reference_angle;
    int          turn_count;

    hall_angle_decoder_with_direction dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out predict_hall_result(input t_in s);
        logic [2:0]         code;
        int                 deg;
        logic [15:0]        a;
        logic signed [15:0] delta;
        t_out               r;
        code = {s.hall_u, s.hall_v, s.hall_w};
        r = '0;
        r.fault = FAULT_NONE;
        if (cfg_shadow.decode_enable) begin
            if (code != CODE_ALL_LOW && code != CODE_ALL_HIGH) begin
                case (code)
                    3'd1:    deg = 330;
                    3'd2:    deg = 210;
                    3'd3:    deg = 270;
                    3'd4:    deg = 90;
                    3'd5:    deg = 30;
                    default: deg = 150;
                endcase
                a = 16'((deg * 65536) / 360);
                if (cfg_shadow.angle_mirror) begin
                    a = 16'd0 - a;
                end
                predicted_angle = a;
            end else if (s.run_active && cfg_shadow.fault_enable) begin
                r.fault = (code == CODE_ALL_HIGH) ? FAULT_HIGH : FAULT_LOW;
            end
        end
        // wrapped change since the last reference point
        delta = predicted_angle - reference_angle;
        if (delta > STEP_THRESHOLD) begin
            if (turn_count < COUNT_MAX) begin
                turn_count++;
            end
            reference_angle = predicted_angle;
        end else if (delta < -STEP_THRESHOLD) begin
            if (turn_count > COUNT_MIN) begin
                turn_count--;
            end
            reference_angle = predicted_angle;
        end
        if (turn_count > DIR_DECIDE) begin
            r.direction = DIR_FWD;
        end else if (turn_count < -DIR_DECIDE) begin
            r.direction = DIR_BWD;
        end else begin
            r.direction = DIR_NONE;
        end
        r.elec_angle = predicted_angle;
        r.abs_position = predicted_angle + cfg_shadow.rotor_zero;
        return r;
    endfunction

    // Sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (hall_samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data <= hall_samples_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predictor, result checker and watchdog
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            cfg_shadow = '0;
            predicted_angle = '0;
            reference_angle = '0;
            turn_count = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DECODE_ENABLE: cfg_shadow.decode_enable = i_cfg_data[0];
                    REG_ANGLE_MIRROR:  cfg_shadow.angle_mirror = i_cfg_data[0];
                    REG_FAULT_ENABLE:  cfg_shadow.fault_enable = i_cfg_data[0];
                    REG_ROTOR_ZERO:    cfg_shadow.rotor_zero = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                expected_results_q.push_back(predict_hall_result(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results_q.size() == 0) begin
                    $error("result with nothing expected: %h", o_out_data);
                    mismatch_count++;
                end else begin
                    exp_r = expected_results_q.pop_front();
                    if (o_out_data.elec_angle !== exp_r.elec_angle) begin
                        $error("elec_angle: expected %0d, got %0d",
                               exp_r.elec_angle, o_out_data.elec_angle);
                        mismatch_count++;
                    end
                    if (o_out_data.abs_position !== exp_r.abs_position) begin
                        $error("abs_position: expected %0d, got %0d",
                               exp_r.abs_position, o_out_data.abs_position);
                        mismatch_count++;
                    end
                    if (o_out_data.direction !== exp_r.direction) begin
                        $error("direction: expected %0d, got %0d",
                               exp_r.direction, o_out_data.direction);
                        mismatch_count++;
                    end
                    if (o_out_data.fault !== exp_r.fault) begin
                        $error("fault: expected %0d, got %0d",
                               exp_r.fault, o_out_data.fault);
                        mismatch_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_sample(input logic [2:0] code, input logic run);
        t_in s;
        {s.hall_u, s.hall_v, s.hall_w} = code;
        s.run_active = run;
        hall_samples_q.push_back(s);
    endtask

    // Hold until every sample is sent and every result is back, then drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (hall_samples_q.size() != 0 || i_in_valid || expected_results_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] dec, input logic [CFG_DATA_W-1:0] mir,
                              input logic [CFG_DATA_W-1:0] flt, input logic [CFG_DATA_W-1:0] rot);
        write_register(REG_DECODE_ENABLE, dec);
        write_register(REG_ANGLE_MIRROR, mir);
        write_register(REG_FAULT_ENABLE, flt);
        write_register(REG_ROTOR_ZERO, rot);
        @(negedge i_clk);
    endtask

    // Rotor turning with random reversals and pauses, plus some sensor noise
    task automatic queue_rotation(input int n);
        int pos;
        int step;
        int r;
        logic [2:0] code;
        pos = $urandom_range(5);
        step = $urandom_range(1) ? 1 : 5;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                code = 3'($urandom_range(7));
            end else begin
                if (r < 14) begin
                    step = 6 - step;
                end
                if (r >= 22) begin
                    pos = (pos + step) % 6;
                end
                code = FWD_CODES[pos];
            end
            queue_sample(code, $urandom_range(99) < 90);
        end
    endtask

    initial begin
        logic [15:0] rot;
        int pos;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: masked register bits, spare indexes ignored, every sector,
        // both invalid codes with and without run, half-turn jumps
        set_config(16'hFFFF, 16'hFFFE, 16'h0001, 16'hFFFF);
        write_register(REG_SPARE_LO, 16'h0000);
        write_register(REG_SPARE_HI, 16'h1234);
        @(negedge i_clk);
        for (int k = 0; k < 6; k++) begin
            queue_sample(FWD_CODES[k], 1'b1);
        end
        queue_sample(CODE_ALL_HIGH, 1'b1);
        queue_sample(CODE_ALL_LOW, 1'b1);
        queue_sample(CODE_ALL_HIGH, 1'b0);
        queue_sample(CODE_ALL_LOW, 1'b0);
        queue_sample(FWD_CODES[2], 1'b1);
        queue_sample(FWD_CODES[5], 1'b1);
        queue_sample(FWD_CODES[4], 1'b1);
        queue_sample(FWD_CODES[3], 1'b1);
        wait_idle();

        // Decoding off: angle held, no fault
        write_register(REG_DECODE_ENABLE, 16'h0000);
        @(negedge i_clk);
        queue_sample(FWD_CODES[0], 1'b1);
        queue_sample(CODE_ALL_LOW, 1'b1);
        wait_idle();

        // Mirrored, faults masked, zero offset
        set_config(16'h0001, 16'h0001, 16'h0000, 16'h0000);
        for (int k = 0; k < 6; k++) begin
            queue_sample(FWD_CODES[k], 1'b1);
        end
        queue_sample(CODE_ALL_LOW, 1'b1);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case ($urandom_range(3))
                0: rot = 16'h0000;
                1: rot = 16'hFFFF;
                default: rot = 16'($urandom());
            endcase
            if ($urandom_range(3) == 0) begin
                write_register(8'($urandom_range(int'(REG_SPARE_HI), int'(REG_SPARE_LO))),
                               16'($urandom()));
            end
            set_config(16'($urandom_range(99) < 85), 16'($urandom_range(1)),
                       16'($urandom_range(1)), rot);
            queue_rotation(PHASE_ITEMS);
            wait_idle();
        end

        // Steady forward turn, then a longer reverse turn back through zero
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_config(16'h0001, 16'h0000, 16'h0001, 16'($urandom()));
        pos = 0;
        for (int k = 0; k < SWEEP_UP + SWEEP_DOWN; k++) begin
            pos = (k < SWEEP_UP) ? (pos + 1) % 6 : (pos + 5) % 6;
            queue_sample(FWD_CODES[pos], 1'($urandom_range(1)));
        end
        wait_idle();
        repeat (6) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hadd_pkg.sv
hdl/hadd_cfg_regs.sv
hdl/hadd_sector_decode.sv
hdl/hadd_dir_track.sv
hdl/hall_angle_decoder_with_direction.sv
tb/sv/tb_hall_angle_decoder_with_direction.sv
